### sv/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types, constants and the open-circuit-voltage curve of the
// battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int SPR_DEFAULT = 16;

  localparam int SUM_W   = 18;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int MV_W    = 16;
  localparam int PCT_W   = 7;
  localparam int CURVE_POINTS = 11;

  // Shared serial divider operand widths
  localparam int DIV_AW = 24;
  localparam int DIV_BW = 12;

  localparam logic [11:0] PIN_FULL_MV   = 12'd3100;
  localparam logic [11:0] ADC_FULL_CODE = 12'd4095;
  localparam logic [12:0] OCV_TOP_MV    = 13'd4160;
  localparam logic [12:0] OCV_BOTTOM_MV = 13'd2990;
  localparam logic [6:0]  PCT_FULL      = 7'd100;
  localparam logic [6:0]  PCT_STEP      = 7'd10;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_DIV_NUM = 2'd1;
  localparam logic [1:0] REG_DIV_DEN = 2'd2;

  typedef struct packed {
    logic [11:0] sample;
    logic        read_ok;
  } sample_t;

  typedef struct packed {
    logic [MV_W-1:0]  millivolt;
    logic [PCT_W-1:0] percent;
  } result_t;

  typedef struct packed {
    logic       enable;
    logic [3:0] divider_num;
    logic [3:0] divider_den;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_AVG,
    DIV_MV,
    DIV_SOC
  } div_sel_t;

  typedef struct packed {
    logic     accum;
    logic     div_start;
    div_sel_t div_sel;
    logic     pin_mul;
    logic     pin_est;
    logic     pin_fix;
    logic     smooth;
    logic     soc_eval;
    logic     pct_load;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic div_done;
    logic soc_direct;
  } dp_stat_t;

  function automatic logic [12:0] ocv_mv(input logic [3:0] idx);
    logic [12:0] mv;
    case (idx)
      4'd0:    mv = 13'd4160;
      4'd1:    mv = 13'd4020;
      4'd2:    mv = 13'd3940;
      4'd3:    mv = 13'd3870;
      4'd4:    mv = 13'd3810;
      4'd5:    mv = 13'd3760;
      4'd6:    mv = 13'd3740;
      4'd7:    mv = 13'd3720;
      4'd8:    mv = 13'd3680;
      4'd9:    mv = 13'd3620;
      default: mv = 13'd2990;
    endcase
    return mv;
  endfunction

endpackage

### sv/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Averages batches of converter samples into smoothed battery millivolts and
// a state-of-charge percent from an open-circuit-voltage curve.
// ----------------------------------------------------------------------------
// A sample that does not end a batch is taken in the idle state. The sample that
// ends a batch with at least one good read occupies the block for the batch-end
// arithmetic: the average, the divider ratio and the curve interpolation each
// run through one shared serial divider, a start state and then 24 steps; the
// pin scaling takes an estimate step and a correction step of reciprocal
// arithmetic; the interpolation step is skipped at the curve ends.
// sample_stall is high over that time, and longer while an earlier result
// still waits on result_stall. A finished result waits in the output register
// while the next batch is taken.
module battery_voltage_monitor import bvm_pkg::*; #(
  parameter int SAMPLES_PER_READ = SPR_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample_data,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b0;
      cfg.divider_num <= 4'd3;
      cfg.divider_den <= 4'd1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ENABLE:  cfg.enable      <= pwdata[0];
        REG_DIV_NUM: cfg.divider_num <= pwdata[3:0];
        REG_DIV_DEN: cfg.divider_den <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:  prdata = {31'd0, cfg.enable};
      REG_DIV_NUM: prdata = {28'd0, cfg.divider_num};
      REG_DIV_DEN: prdata = {28'd0, cfg.divider_den};
      default:     prdata = '0;
    endcase
  end

  bvm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  bvm_dp #(
    .SAMPLES_PER_READ (SAMPLES_PER_READ)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sample_data (sample_data),
    .cmd         (cmd),
    .stat        (stat),
    .result_data (result_data)
  );

endmodule

### sv/bvm_div.sv
// ----------------------------------------------------------------------------
// bvm_div
// Restoring divider, one quotient bit per cycle, shared by the batch-end
// divisions by a variable divisor.
// ----------------------------------------------------------------------------
module bvm_div import bvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_AW-1:0] dividend,
  input  logic [DIV_BW-1:0] divisor,
  output logic              done,
  output logic [DIV_AW-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_AW);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_BW-1:0] rem;
  logic [DIV_BW-1:0] dvsr;
  logic [DIV_AW-1:0] quo;
  logic [DIV_BW:0]   rem_sh;
  logic              fits;

  assign rem_sh   = {rem, quo[DIV_AW-1]};
  assign fits     = rem_sh >= {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_AW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_AW-2:0], fits};
      rem <= fits ? DIV_BW'(rem_sh - {1'b0, dvsr}) : rem_sh[DIV_BW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

### sv/bvm_dp.sv
// ----------------------------------------------------------------------------
// bvm_dp
// Datapath: batch accumulation, pin scaling, operand selection for the shared
// divider, smoothing, curve interpolation and the result register.
// ----------------------------------------------------------------------------
module bvm_dp import bvm_pkg::*; #(
  parameter int SAMPLES_PER_READ = SPR_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  sample_t  sample_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output result_t  result_data
);

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] good_count;
  logic [INDEX_W-1:0] batch_index;
  logic [MV_W-1:0]    smoothed_mv;
  logic [PCT_W-1:0]   percent;
  logic [PCT_W-1:0]   seg_base;
  logic [23:0]        pin_prod;
  logic [11:0]        pin_est;
  logic [11:0]        pin_mv;

  logic [COUNT_W-1:0] count_next;
  logic               batch_last;
  logic               div_done;
  logic [DIV_AW-1:0]  quotient;
  logic [DIV_AW-1:0]  div_a;
  logic [DIV_BW-1:0]  div_b;
  logic [3:0]         den_eff;
  logic [17:0]        smooth_sum;
  logic [24:0]        pin_sum;
  logic [23:0]        pin_back;
  logic [23:0]        pin_rem;
  logic [3:0]         seg;
  logic [12:0]        seg_hi;
  logic [12:0]        seg_lo;
  logic [9:0]         seg_span;
  logic [9:0]         seg_off;
  logic               at_top;
  logic               at_bottom;

  assign count_next = good_count + COUNT_W'(sample_data.read_ok);
  assign batch_last = batch_index == INDEX_W'(SAMPLES_PER_READ - 1);
  assign den_eff    = (cfg.divider_den == 4'd0) ? 4'd1 : cfg.divider_den;
  assign smooth_sum = 18'({smoothed_mv, 1'b0}) + 18'(smoothed_mv) + 18'(quotient[MV_W-1:0]);

  // Divide by 4095: estimate low by at most one, then correct
  assign pin_sum  = {1'b0, pin_prod} + 25'(pin_prod[23:12]);
  assign pin_back = {pin_est, 12'd0} - 24'(pin_est);
  assign pin_rem  = pin_prod - pin_back;

  assign at_top    = smoothed_mv >= MV_W'(OCV_TOP_MV);
  assign at_bottom = smoothed_mv <= MV_W'(OCV_BOTTOM_MV);

  always_comb begin
    seg = 4'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (smoothed_mv >= MV_W'(ocv_mv(4'(i)))) seg = 4'(i);
    end
  end

  assign seg_hi   = ocv_mv(seg - 4'd1);
  assign seg_lo   = ocv_mv(seg);
  assign seg_span = 10'(seg_hi - seg_lo);
  assign seg_off  = 10'(smoothed_mv - MV_W'(seg_lo));

  always_comb begin
    case (cmd.div_sel)
      DIV_AVG: begin
        div_a = DIV_AW'(sample_sum);
        div_b = DIV_BW'(good_count);
      end
      DIV_MV: begin
        div_a = DIV_AW'(pin_mv) * DIV_AW'(cfg.divider_num);
        div_b = DIV_BW'(den_eff);
      end
      DIV_SOC: begin
        div_a = DIV_AW'(seg_off) * DIV_AW'(PCT_STEP);
        div_b = DIV_BW'(seg_span);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  bvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quotient)
  );

  assign stat.fire       = batch_last && (count_next != '0);
  assign stat.div_done   = div_done;
  assign stat.soc_direct = at_top || at_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum  <= '0;
      good_count  <= '0;
      batch_index <= '0;
      smoothed_mv <= '0;
    end else begin
      if (cmd.accum) begin
        if (sample_data.read_ok) sample_sum <= sample_sum + SUM_W'(sample_data.sample);
        good_count <= count_next;
        if (batch_last) begin
          batch_index <= '0;
          if (count_next == '0) sample_sum <= '0;
        end else begin
          batch_index <= batch_index + 1'b1;
        end
      end
      if (cmd.div_start && cmd.div_sel == DIV_AVG) begin
        sample_sum <= '0;
        good_count <= '0;
      end
      if (cmd.smooth) begin
        smoothed_mv <= (smoothed_mv != '0) ? smooth_sum[17:2] : quotient[MV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pin_mul) pin_prod <= 24'(quotient[11:0]) * 24'(PIN_FULL_MV);
    if (cmd.pin_est) pin_est <= pin_sum[23:12];
    if (cmd.pin_fix) pin_mv <= (pin_rem >= 24'(ADC_FULL_CODE)) ? pin_est + 12'd1 : pin_est;
    if (cmd.soc_eval) begin
      if (at_top) percent <= PCT_FULL;
      else if (at_bottom) percent <= '0;
      seg_base <= PCT_FULL - PCT_W'(seg) * PCT_STEP;
    end
    if (cmd.pct_load) percent <= seg_base + quotient[PCT_W-1:0];
    if (cmd.load_out) begin
      result_data.millivolt <= smoothed_mv;
      result_data.percent   <= percent;
    end
  end

`ifndef SYNTHESIS
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    good_count == '0 |-> sample_sum == '0)
    else $error("sum nonzero with no good samples");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    good_count <= COUNT_W'(SAMPLES_PER_READ))
    else $error("good count beyond batch length");
`endif

endmodule

### sv/bvm_ctrl.sv
// ----------------------------------------------------------------------------
// bvm_ctrl
// Controller: takes samples, sequences the batch-end arithmetic and the
// result transfer.
// ----------------------------------------------------------------------------
module bvm_ctrl import bvm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     sample_valid,
  output logic     sample_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    W_AVG,
    S_PIN_EST,
    S_PIN_FIX,
    S_MV,
    W_MV,
    S_SOC,
    W_SOC,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign sample_stall = state != S_IDLE;
  assign slot_free    = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_AVG;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.accum = sample_valid && cfg.enable;
        if (cmd.accum && stat.fire) state_next = S_AVG;
      end
      S_AVG: begin
        cmd.div_start = 1'b1;
        state_next    = W_AVG;
      end
      W_AVG: begin
        cmd.pin_mul = stat.div_done;
        if (stat.div_done) state_next = S_PIN_EST;
      end
      S_PIN_EST: begin
        cmd.pin_est = 1'b1;
        state_next  = S_PIN_FIX;
      end
      S_PIN_FIX: begin
        cmd.pin_fix = 1'b1;
        state_next  = S_MV;
      end
      S_MV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MV;
        state_next    = W_MV;
      end
      W_MV: begin
        cmd.smooth = stat.div_done;
        if (stat.div_done) state_next = S_SOC;
      end
      S_SOC: begin
        cmd.soc_eval  = 1'b1;
        cmd.div_sel   = DIV_SOC;
        cmd.div_start = !stat.soc_direct;
        state_next    = stat.soc_direct ? S_OUT : W_SOC;
      end
      W_SOC: begin
        cmd.pct_load = stat.div_done;
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.load_out = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_fire_avg: assert property (@(posedge clk) disable iff (rst)
    cmd.accum && stat.fire |=> state == S_AVG)
    else $error("batch end did not start averaging");
`endif

endmodule
